>>> sv/sbe_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sbe_pkg: shared types and constants of the stack bytecode executor
// Opcode values, request and result payload structs, and the command struct
// that the controller sends to the datapath.
// ============================================================================
package sbe_pkg;

    // Opcodes of one instruction.
    localparam logic [2:0] BC_PUSH  = 3'd0;
    localparam logic [2:0] BC_PRINT = 3'd1;
    localparam logic [2:0] BC_READ  = 3'd2;
    localparam logic [2:0] BC_IADD  = 3'd3;
    localparam logic [2:0] BC_STOP  = 3'd4;

    // Width of one stack entry.
    localparam int unsigned DATA_W = 64;

    // One instruction request.
    typedef struct packed {
        logic [2:0]               op;
        logic signed [DATA_W-1:0] immediate;
        logic signed [DATA_W-1:0] read_value;
        logic                     read_ok;
    } sbe_req_t;

    // One result.
    typedef struct packed {
        logic                     print_valid;
        logic signed [DATA_W-1:0] print_value;
        logic                     halted;
        logic                     overflow;
    } sbe_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;  // latch the request and start the stack read
        logic exec;    // commit the instruction and load the result register
    } sbe_cmd_t;

endpackage

>>> sv/sbe_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// sbe_datapath: stack storage and instruction execution
// Holds the top of stack in a register and the entries beneath it in a
// memory with one write and one registered read port.
// ============================================================================
module sbe_datapath #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  sbe_pkg::sbe_cmd_t cmd,
    input  sbe_pkg::sbe_req_t req_in,
    output sbe_pkg::sbe_rsp_t rsp_out
);

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned DW = sbe_pkg::DATA_W;

    // Entries below the top of stack. Entry i holds stack position i.
    logic [DW-1:0] mem [STACK_DEPTH];

    sbe_pkg::sbe_req_t req_reg;
    sbe_pkg::sbe_rsp_t rsp_reg, rsp_next;
    logic [DW-1:0]     top_reg, top_next;
    logic [DW-1:0]     rdata_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic              stopped_reg, stopped_next;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic              is_empty;
    logic              is_full;
    logic              has_two;
    logic [DW-1:0]     push_val;
    logic [DW-1:0]     opnd_a;
    logic [DW-1:0]     opnd_b;

    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(STACK_DEPTH));
    assign has_two  = (count_reg >= CW'(2));

    // The entry just below the top sits at position count - 2.
    assign rd_addr = cnt_m2[AW-1:0];
    assign wr_addr = cnt_m1[AW-1:0];

    // Request latch, control state and result register.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg   <= req_in;
            rdata_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= top_reg;
        end
        if (cmd.exec) begin
            rsp_reg <= rsp_next;
            top_reg <= top_next;
        end
        if (!aresetn) begin
            count_reg   <= '0;
            stopped_reg <= 1'b0;
        end else if (cmd.exec) begin
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

    // Instruction execution on the latched request.
    always_comb begin
        push_val     = (req_reg.op == sbe_pkg::BC_PUSH) ? req_reg.immediate
                                                        : req_reg.read_value;
        opnd_b       = is_empty ? '0 : top_reg;
        opnd_a       = has_two ? rdata_reg : '0;
        rsp_next     = '0;
        top_next     = top_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        wr_en        = 1'b0;
        if (stopped_reg) begin
            rsp_next.halted = 1'b1;
        end else begin
            unique case (req_reg.op) inside
                sbe_pkg::BC_PUSH, sbe_pkg::BC_READ: begin
                    if (req_reg.op == sbe_pkg::BC_PUSH || req_reg.read_ok) begin
                        if (is_full) begin
                            rsp_next.overflow = 1'b1;
                        end else begin
                            // Spill the old top into memory unless the stack was empty.
                            wr_en      = cmd.exec && !is_empty;
                            top_next   = push_val;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                sbe_pkg::BC_PRINT: begin
                    if (!is_empty) begin
                        rsp_next.print_valid = 1'b1;
                        rsp_next.print_value = top_reg;
                        top_next             = rdata_reg;
                        count_next           = cnt_m1;
                    end
                end
                sbe_pkg::BC_IADD: begin
                    // Missing operands count as zero; the sum always lands on top.
                    top_next   = opnd_a + opnd_b;
                    count_next = has_two ? cnt_m1 : CW'(1);
                end
                sbe_pkg::BC_STOP: begin
                    stopped_next    = 1'b1;
                    rsp_next.halted = 1'b1;
                end
                default: begin
                    rsp_next = '0;
                end
            endcase
        end
    end

    assign rsp_out = rsp_reg;

`ifndef SYNTH
    // The stack never holds more values than it has room for.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // Once stopped, the machine stays stopped until reset.
    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stopped flag cleared without reset");

    // An add always leaves at least one value on the stack.
    a_add_leaves_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && !stopped_reg && req_reg.op == sbe_pkg::BC_IADD)
        |=> (count_reg != '0))
        else $error("add left an empty stack");
`endif

endmodule

>>> sv/sbe_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// sbe_ctrl: request sequencing for the stack bytecode executor
// Takes a request, registers the stack read, then commits the instruction
// once the result register is free.
// ============================================================================
module sbe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output sbe_pkg::sbe_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    // The result register can be loaded when empty or being drained now.
    assign out_free = !m_valid_reg || m_ready;

    // Next state and command decode.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    cmd.exec     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef SYNTH
    // An accepted request always moves on to execution.
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted request did not enter execution");

    // Execution with a free result register presents a result next cycle.
    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("execution did not produce a result");

    // A blocked result holds execution in place.
    a_exec_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && m_valid_reg && !m_ready) |=> (state_reg == ST_EXEC))
        else $error("execution overwrote a pending result");
`endif

endmodule

>>> sv/stack_bytecode_executor_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// stack_bytecode_executor_unit: stack-machine instruction executor
// Executes one push, print, read, add or stop instruction per request over
// a 64-bit data stack of STACK_DEPTH entries.
// ============================================================================
// Usage:
//   Requests arrive on s_valid/s_ready with s_payload; each one produces
//   exactly one result on m_valid/m_ready with m_payload, in order.
//   A request is taken only when the unit is idle. The accepting edge reads
//   the entry below the top of stack; the instruction is then committed into
//   the result register, raising m_valid, once that register is free.
//   A new request is taken only after the previous one has been committed
//   into the result register.
//   If the receiver stalls, the next request is still taken but holds in
//   execution until the result register drains; s_ready stays low meanwhile.
//   After reset the stack is empty and the unit is running; stack memory
//   is not cleared, since entries that were never written are never used.
//   After a stop, every request returns halted and changes nothing.
// ============================================================================
module stack_bytecode_executor_unit #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sbe_pkg::sbe_req_t s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output sbe_pkg::sbe_rsp_t m_payload
);

    sbe_pkg::sbe_cmd_t cmd;

    // Sequencing of requests and results.
    sbe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Stack storage and execution.
    sbe_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .req_in  (s_payload),
        .rsp_out (m_payload)
    );

endmodule
